// File: rtl/rrr_pkg.sv
// Shared types and constants for the round-robin ready ring.
// Used by rrr_succ_mem, rrr_ctrl and round_robin_ready_ring.
package rrr_pkg;

  localparam int NUM_TASKS = 64;
  localparam int ID_W      = 6;
  localparam int ADDR_W    = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int CNT_W     = $clog2(NUM_TASKS + 1);

  localparam int CMD_W  = 2;
  localparam int STAT_W = 2;

  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_NEXT   = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;

  typedef logic [ID_W-1:0]   id_t;
  typedef logic [ADDR_W-1:0] addr_t;

  // One access of the successor table per cycle.
  typedef struct packed {
    logic  we;
    addr_t waddr;
    id_t   wdata;
    addr_t raddr;
  } mem_req_t;

  typedef struct packed {
    id_t               current_task;
    logic              is_empty;
    logic [STAT_W-1:0] status;
  } res_t;

  function automatic addr_t to_addr(input id_t id);
    return ADDR_W'(id);
  endfunction

endpackage

// File: rtl/rrr_succ_mem.sv
// Successor table of the ready ring: one write and one registered read a cycle.
// Depends on rrr_pkg.
module rrr_succ_mem
  import rrr_pkg::*;
(
  input  logic     clk_i,
  input  mem_req_t req_i,
  output id_t      rdata_o
);

  id_t mem_q [NUM_TASKS];
  id_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/rrr_ctrl.sv
// Command sequencer of the ready ring: tail, empty flag, member bits and the
// predecessor walk over the successor table. Depends on rrr_pkg.
module rrr_ctrl
  import rrr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  logic [CMD_W-1:0]  cmd_i,
  input  id_t               id_i,
  output mem_req_t          mem_req_o,
  input  id_t               mem_rdata_i,
  output logic              res_valid_o,
  input  logic              res_free_i,
  output res_t              res_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LINK   = 3'd1;
  localparam logic [2:0] S_WALK   = 3'd2;
  localparam logic [2:0] S_UNLINK = 3'd3;
  localparam logic [2:0] S_NEXT   = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;

  logic [2:0]        state_q, state_d;
  id_t               tail_q, tail_d;
  logic              empty_q, empty_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [NUM_TASKS-1:0] member_q, member_d;
  id_t               id_q, id_d;
  id_t               pred_q, pred_d;
  logic [ADDR_W-1:0] steps_q, steps_d;
  logic [STAT_W-1:0] status_q, status_d;

  logic in_range;
  logic is_member;

  assign in_range  = 32'(id_i) < NUM_TASKS;
  assign is_member = in_range && member_q[to_addr(id_i)];

  always_comb begin
    state_d   = state_q;
    tail_d    = tail_q;
    empty_d   = empty_q;
    count_d   = count_q;
    member_d  = member_q;
    id_d      = id_q;
    pred_d    = pred_q;
    steps_d   = steps_q;
    status_d  = status_q;
    mem_req_o = '{we: 1'b0, waddr: to_addr(tail_q), wdata: id_i, raddr: to_addr(tail_q)};

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          id_d     = id_i;
          status_d = ST_OK;
          state_d  = S_FIN;
          case (cmd_i)
            CMD_ADD: begin
              if (!in_range) begin
                status_d = ST_NOT_FOUND;
              end else if (!is_member) begin
                member_d[to_addr(id_i)] = 1'b1;
                tail_d  = id_i;
                empty_d = 1'b0;
                count_d = count_q + 1'b1;
                if (empty_q) begin
                  // Lone task points at itself.
                  mem_req_o.we    = 1'b1;
                  mem_req_o.waddr = to_addr(id_i);
                  mem_req_o.wdata = id_i;
                end else begin
                  // Link tail -> id now; read old successor of tail.
                  mem_req_o.we = 1'b1;
                  state_d      = S_LINK;
                end
              end
            end
            CMD_REMOVE: begin
              if (empty_q) begin
                status_d = ST_EMPTY;
              end else if (!is_member) begin
                status_d = ST_NOT_FOUND;
              end else if (count_q == CNT_W'(1)) begin
                member_d[to_addr(id_i)] = 1'b0;
                empty_d = 1'b1;
                tail_d  = '0;
                count_d = '0;
              end else begin
                pred_d  = tail_q;
                steps_d = '0;
                state_d = S_WALK;
              end
            end
            CMD_NEXT: begin
              if (empty_q) begin
                status_d = ST_EMPTY;
              end else begin
                state_d = S_NEXT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_LINK: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = to_addr(id_q);
        mem_req_o.wdata = mem_rdata_i;
        state_d         = S_FIN;
      end
      S_WALK: begin
        if (mem_rdata_i == id_q) begin
          mem_req_o.raddr = to_addr(id_q);
          state_d         = S_UNLINK;
        end else if (steps_q == ADDR_W'(NUM_TASKS - 1)) begin
          status_d = ST_NOT_FOUND;
          state_d  = S_FIN;
        end else begin
          pred_d          = mem_rdata_i;
          steps_d         = steps_q + 1'b1;
          mem_req_o.raddr = to_addr(mem_rdata_i);
        end
      end
      S_UNLINK: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = to_addr(pred_q);
        mem_req_o.wdata = mem_rdata_i;
        member_d[to_addr(id_q)] = 1'b0;
        count_d = count_q - 1'b1;
        if (id_q == tail_q) begin
          tail_d = pred_q;
        end
        state_d = S_FIN;
      end
      S_NEXT: begin
        tail_d  = mem_rdata_i;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (res_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      tail_q   <= '0;
      empty_q  <= 1'b1;
      count_q  <= '0;
      member_q <= '0;
    end else begin
      state_q  <= state_d;
      tail_q   <= tail_d;
      empty_q  <= empty_d;
      count_q  <= count_d;
      member_q <= member_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q     <= id_d;
    pred_q   <= pred_d;
    steps_q  <= steps_d;
    status_q <= status_d;
  end

  assign cmd_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_FIN) && res_free_i;
  assign res_o = '{current_task: empty_q ? '0 : tail_q, is_empty: empty_q, status: status_q};

endmodule

// File: rtl/round_robin_ready_ring.sv
// Top level of the round-robin ready ring: stream ports and result register.
// Depends on rrr_pkg, rrr_succ_mem and rrr_ctrl.
//
// Usage: one command beat on the slave side gives exactly one result beat on
// the master side. Command (tuser[1:0]): add, remove or advance; tdata[5:0]
// holds the task id. Result tdata: current task, empty flag and status.
// Sequencing: add of the first task, remove of the only task, rejected
// commands and commands on an empty ring go from accept straight to the
// result state; add to a non-empty ring and advance first go through the
// link or advance state for the successor table read. Remove walks the ring
// from the tail one entry per cycle through the single table read port, up
// to NUM_TASKS - 1 hops to the predecessor. The slave side is ready
// only while no command is in flight. A result sits in an output register;
// the next command is taken while it waits, but its own result holds inside
// the sequencer until the receiver drains the register. Stall the master side
// and the block simply holds. Reset empties the ring at once (member bits
// clear); the successor table needs no clearing, since only member entries
// are read.
module round_robin_ready_ring
  import rrr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [5:0] task_id, [7:6] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [5:0] current_task, [6] is_empty,
                                      // [8:7] status, [15:9] zero
);

  mem_req_t mem_req;
  id_t      mem_rdata;
  logic     res_valid;
  logic     res_free;
  res_t     res;

  logic        m_valid_q;
  logic [15:0] m_data_q;

  // Output register is free when empty or being drained this cycle.
  assign res_free = !m_valid_q || m_axis_tready;

  rrr_succ_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  rrr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (s_axis_tvalid),
    .cmd_ready_o (s_axis_tready),
    .cmd_i       (s_axis_tuser),
    .id_i        (s_axis_tdata[ID_W-1:0]),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata),
    .res_valid_o (res_valid),
    .res_free_i  (res_free),
    .res_o       (res)
  );

  // Load a new result, or drop the valid once the beat is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_valid) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      m_data_q <= {7'd0, res.status, res.is_empty, res.current_task};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // An empty ring always reports task zero.
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[6] |-> m_axis_tdata[5:0] == '0)
    else $error("empty ring result with nonzero task");

  // Status code three is never produced.
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[8:7] != 2'd3)
    else $error("undefined status code");

  // One command in flight: ready drops after an accepted beat.
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("command accepted while busy");

  // A result never overwrites one still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (!m_valid_q || m_axis_tready))
    else $error("result register overwritten");

endmodule

// File: bench/round_robin_ready_ring_test.sv
// Self-checking bench for round_robin_ready_ring: command beats in, one result beat out each.
// Depends on rrr_pkg for ids, commands and status codes; needs only the RTL besides itself.
module round_robin_ready_ring_test;
  import rrr_pkg::*;

  // Command value three carries no operation; the ring must answer it unchanged.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam int unsigned RANDOM_ITEMS = 750;
  localparam int unsigned CYCLE_LIMIT  = 400_000;
  // Longest remove walk plus the result register and some slack.
  localparam int unsigned DRAIN_CYCLES = NUM_TASKS + 32;

  typedef enum logic [1:0] {
    MIX_FILL,
    MIX_DRAIN,
    MIX_EVEN
  } mix_e;

  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_COIN,
    SINK_SLOW,
    SINK_ROTATE
  } sink_e;

  // Tracks the ready ring the same way the block should: successor table, tail,
  // empty flag and membership. Every accepted command queues one result.
  class ready_ring_tracker;
    id_t         succ_of [NUM_TASKS];
    bit          in_ring [NUM_TASKS];
    id_t         tail;
    bit          empty;
    res_t        pending_results[$];
    int unsigned mismatches;

    function new();
      foreach (succ_of[i]) begin
        succ_of[i] = '0;
        in_ring[i] = 1'b0;
      end
      tail       = '0;
      empty      = 1'b1;
      mismatches = 0;
    endfunction

    function void note_command(logic [CMD_W-1:0] cmd, id_t id);
      logic [STAT_W-1:0] status;
      id_t               pred;
      bit                found;
      res_t              want;
      int                step;
      status = ST_OK;
      case (cmd)
        CMD_ADD: begin
          if (int'(id) >= NUM_TASKS) begin
            status = ST_NOT_FOUND;
          end else if (!in_ring[id]) begin
            // Link in after the tail; a lone task points at itself.
            if (empty) begin
              succ_of[id] = id;
            end else begin
              succ_of[id]   = succ_of[tail];
              succ_of[tail] = id;
            end
            in_ring[id] = 1'b1;
            tail        = id;
            empty       = 1'b0;
          end
        end
        CMD_REMOVE: begin
          if (empty) begin
            status = ST_EMPTY;
          end else if (int'(id) >= NUM_TASKS || !in_ring[id]) begin
            status = ST_NOT_FOUND;
          end else if (succ_of[tail] == tail) begin
            in_ring[id] = 1'b0;
            empty       = 1'b1;
            tail        = '0;
          end else begin
            // Walk to the predecessor without touching the tail.
            pred  = tail;
            found = 1'b0;
            for (step = 0; step < NUM_TASKS; step++) begin
              if (succ_of[pred] == id) begin
                found = 1'b1;
                break;
              end
              pred = succ_of[pred];
            end
            if (!found) begin
              status = ST_NOT_FOUND;
            end else begin
              succ_of[pred] = succ_of[id];
              in_ring[id]   = 1'b0;
              if (id == tail) tail = pred;
            end
          end
        end
        CMD_NEXT: begin
          if (empty) status = ST_EMPTY;
          else tail = succ_of[tail];
        end
        default: ;
      endcase
      want.current_task = empty ? id_t'(0) : tail;
      want.is_empty     = empty;
      want.status       = status;
      pending_results.push_back(want);
    endfunction

    function void check_result(logic [15:0] beat);
      res_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing outstanding, expected none actual %h",
                 $time, beat);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      if (beat[5:0] !== want.current_task) begin
        $display("%0t: current_task expected %0d actual %0d", $time, want.current_task,
                 beat[5:0]);
        mismatches++;
      end
      if (beat[6] !== want.is_empty) begin
        $display("%0t: is_empty expected %0d actual %0d", $time, want.is_empty, beat[6]);
        mismatches++;
      end
      if (beat[8:7] !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, beat[8:7]);
        mismatches++;
      end
      if (beat[15:9] !== 7'd0) begin
        $display("%0t: tdata padding expected 0 actual %h", $time, beat[15:9]);
        mismatches++;
      end
    endfunction

    // Find a task that is (or is not) in the ring, starting at a random id.
    function id_t pick_task(bit want_member);
      int  start;
      int  k;
      id_t probe;
      start = $urandom_range(0, NUM_TASKS - 1);
      for (k = 0; k < NUM_TASKS; k++) begin
        probe = id_t'((start + k) % NUM_TASKS);
        if (in_ring[probe] == want_member) return probe;
      end
      return id_t'(start);
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;   // [5:0] task_id, [7:6] zero
  logic [1:0]  s_axis_tuser  = '0;   // [1:0] command
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // [5:0] current_task, [6] is_empty,
                                     // [8:7] status, [15:9] zero

  ready_ring_tracker ring = new();

  int unsigned cycle_count = 0;
  sink_e       sink_mode   = SINK_OPEN;
  int unsigned sink_left   = 0;
  logic [7:0]  sink_rotor  = 8'b1011_0010;

  round_robin_ready_ring i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Watch both handshakes at the edge. The block drives its outputs with
  // nonblocking updates, so the values read here are the ones the edge saw.
  // A command can never answer at its own accept edge, so note it first.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) ring.note_command(s_axis_tuser, s_axis_tdata[5:0]);
      if (m_axis_tvalid && m_axis_tready) ring.check_result(m_axis_tdata);
    end
  end

  // Receiver: switch between stall styles at random intervals so that
  // stalls land on every stage of a walk, with fully open stretches too.
  always @(posedge clk_i) begin
    if (sink_left == 0) begin
      sink_mode <= sink_e'($urandom_range(0, 3));
      sink_left <= $urandom_range(16, 96);
    end else begin
      sink_left <= sink_left - 1;
    end
    sink_rotor <= {sink_rotor[6:0], sink_rotor[7]};
    case (sink_mode)
      SINK_OPEN:   m_axis_tready <= 1'b1;
      SINK_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
      SINK_SLOW:   m_axis_tready <= ($urandom_range(0, 3) == 0);
      SINK_ROTATE: m_axis_tready <= sink_rotor[0];
      default:     m_axis_tready <= 1'b1;
    endcase
  end

  // Bound the run; a hung handshake ends here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Present one command beat and hold it until the accept edge. On return the
  // caller is at that edge and may present the next beat without a gap.
  task automatic send_command(input logic [CMD_W-1:0] cmd, input id_t id);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {2'b00, id};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic pause_sender(input int unsigned cycles);
    s_axis_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Draw one random command. Fill phases favor adding absent tasks, drain
  // phases favor removing present ones; a share of removes miss on purpose.
  task automatic draw_command(input mix_e mix, output logic [CMD_W-1:0] cmd,
                              output id_t id);
    int unsigned roll;
    int unsigned add_cut;
    int unsigned remove_cut;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  begin add_cut = 55; remove_cut = 75; end
      MIX_DRAIN: begin add_cut = 20; remove_cut = 75; end
      default:   begin add_cut = 35; remove_cut = 65; end
    endcase
    id = id_t'($urandom_range(0, NUM_TASKS - 1));
    if (roll < add_cut) begin
      cmd = CMD_ADD;
      if (mix == MIX_FILL && $urandom_range(0, 9) < 7) id = ring.pick_task(1'b0);
    end else if (roll < remove_cut) begin
      cmd = CMD_REMOVE;
      if ($urandom_range(0, 3) != 0) id = ring.pick_task(1'b1);
    end else if (roll < 95) begin
      cmd = CMD_NEXT;
    end else begin
      cmd = CMD_UNUSED;
    end
  endtask

  initial begin
    logic [CMD_W-1:0] cmd;
    id_t              id;
    mix_e             mix;
    int unsigned      sent;
    int unsigned      burst;
    int unsigned      next_mix_at;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty-ring commands, the unused code, the lone task removed,
    // a duplicate add, a miss, removal from the middle and at the tail, and
    // the id extremes.
    send_command(CMD_NEXT,   6'd0);
    send_command(CMD_REMOVE, 6'd5);
    send_command(CMD_UNUSED, 6'd0);
    send_command(CMD_ADD,    6'd63);
    send_command(CMD_REMOVE, 6'd63);
    send_command(CMD_NEXT,   6'd63);
    send_command(CMD_ADD,    6'd0);
    send_command(CMD_ADD,    6'd63);
    send_command(CMD_ADD,    6'd0);
    send_command(CMD_NEXT,   6'd0);
    send_command(CMD_NEXT,   6'd0);
    send_command(CMD_REMOVE, 6'd42);
    send_command(CMD_ADD,    6'd21);
    send_command(CMD_ADD,    6'd42);
    send_command(CMD_REMOVE, 6'd21);
    send_command(CMD_REMOVE, 6'd42);
    send_command(CMD_NEXT,   6'd0);
    send_command(CMD_UNUSED, 6'd63);
    send_command(CMD_ADD,    6'd42);
    send_command(CMD_REMOVE, 6'd0);
    send_command(CMD_REMOVE, 6'd63);
    send_command(CMD_REMOVE, 6'd42);
    send_command(CMD_ADD,    6'd21);
    pause_sender(3);

    // Random: bursts of commands with random gaps; switch the mix now and
    // then so the ring swings between nearly full and empty.
    sent        = 0;
    mix         = MIX_FILL;
    next_mix_at = 120;
    while (sent < RANDOM_ITEMS) begin
      if (sent >= next_mix_at) begin
        mix         = mix_e'($urandom_range(0, 2));
        next_mix_at = sent + $urandom_range(40, 160);
      end
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        draw_command(mix, cmd, id);
        send_command(cmd, id);
        if (cmd != CMD_UNUSED) sent++;
      end
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 6));
    end
    s_axis_tvalid <= 1'b0;

    // Wait for every result, then give any stray beat time to show up.
    while (ring.pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (ring.mismatches == 0 && ring.pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
